/* hw/rtl/sbma_pkg.sv */
package sbma_pkg;

  localparam int BIN_W   = 16;
  localparam int MAG_W   = 16;
  localparam int POW_W   = 32;
  localparam int SUM_W   = 24;
  localparam int WIDTH_W = 9;
  localparam int TOTAL_W = 10;
  localparam int BAND_W  = 9;

  // every serial unit runs eight steps of two bits
  localparam logic [2:0] STEP_LAST = 3'd7;

  localparam logic [WIDTH_W-1:0] WIDTH_MAX   = 9'd256;
  localparam logic [TOTAL_W-1:0] TOTAL_MAX   = 10'd512;
  localparam logic [WIDTH_W-1:0] WIDTH_RESET = 9'd16;
  localparam logic [TOTAL_W-1:0] TOTAL_RESET = 10'd128;

  localparam logic REG_BAND_WIDTH = 1'b0;
  localparam logic REG_BAND_TOTAL = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_ROOT,
    ST_ACCUM,
    ST_DIVIDE,
    ST_EMIT
  } state_t;

endpackage

/* hw/rtl/sbma_square.sv */
module sbma_square (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic signed [sbma_pkg::BIN_W-1:0] re,
  input  logic signed [sbma_pkg::BIN_W-1:0] im,
  output logic                           done,
  output logic [sbma_pkg::POW_W-1:0]     power
);

  logic [15:0] abs_re;
  logic [15:0] abs_im;
  logic [15:0] mcand_a;
  logic [15:0] mcand_b;
  logic [15:0] mplier_a;
  logic [15:0] mplier_b;
  logic [16:0] hi;
  logic [15:0] lo;
  logic [2:0]  cnt;
  logic        busy;
  logic [18:0] part_a;
  logic [18:0] part_b;
  logic [18:0] hi_sum;

  assign abs_re = re[15] ? (~re + 16'd1) : re;
  assign abs_im = im[15] ? (~im + 16'd1) : im;

  // radix-4 shift-add: both squares share one accumulator
  always_comb begin
    part_a = ({19{mplier_a[0]}} & {3'd0, mcand_a})
           + ({19{mplier_a[1]}} & {2'd0, mcand_a, 1'b0});
    part_b = ({19{mplier_b[0]}} & {3'd0, mcand_b})
           + ({19{mplier_b[1]}} & {2'd0, mcand_b, 1'b0});
    hi_sum = {2'd0, hi} + part_a + part_b;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && (cnt == sbma_pkg::STEP_LAST);
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 3'd1;
        if (cnt == sbma_pkg::STEP_LAST) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      mcand_a  <= abs_re;
      mcand_b  <= abs_im;
      mplier_a <= abs_re;
      mplier_b <= abs_im;
      hi       <= '0;
      lo       <= '0;
    end else if (busy) begin
      mplier_a <= {2'd0, mplier_a[15:2]};
      mplier_b <= {2'd0, mplier_b[15:2]};
      hi       <= hi_sum[18:2];
      lo       <= {hi_sum[1:0], lo[15:2]};
    end
  end

  // sum of squares is at most 2^31
  assign power = {hi[15:0], lo};

endmodule

/* hw/rtl/sbma_isqrt.sv */
module sbma_isqrt (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [sbma_pkg::POW_W-1:0] radicand,
  output logic                       done,
  output logic [sbma_pkg::MAG_W-1:0] root
);

  logic [31:0] rad;
  logic [16:0] rem;
  logic [2:0]  cnt;
  logic        busy;
  logic [31:0] rad_next;
  logic [16:0] rem_next;
  logic [15:0] root_next;
  logic [18:0] rs;
  logic [18:0] trial;
  logic [18:0] diff;

  // two result bits per cycle, restoring
  always_comb begin
    rad_next  = rad;
    rem_next  = rem;
    root_next = root;
    rs        = '0;
    trial     = '0;
    diff      = '0;
    for (int i = 0; i < 2; i++) begin
      rs       = {rem_next, rad_next[31:30]};
      rad_next = {rad_next[29:0], 2'b00};
      trial    = {1'b0, root_next, 2'b01};
      diff     = rs - trial;
      if (rs >= trial) begin
        rem_next  = diff[16:0];
        root_next = {root_next[14:0], 1'b1};
      end else begin
        rem_next  = rs[16:0];
        root_next = {root_next[14:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && (cnt == sbma_pkg::STEP_LAST);
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 3'd1;
        if (cnt == sbma_pkg::STEP_LAST) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rad  <= radicand;
      rem  <= '0;
      root <= '0;
    end else if (busy) begin
      rad  <= rad_next;
      rem  <= rem_next;
      root <= root_next;
    end
  end

endmodule

/* hw/rtl/sbma_divide.sv */
module sbma_divide (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [sbma_pkg::SUM_W-1:0]   dividend,
  input  logic [sbma_pkg::WIDTH_W-1:0] divisor,
  output logic                         done,
  output logic [sbma_pkg::MAG_W-1:0]   quotient
);

  logic [8:0]  div;
  logic [8:0]  rem;
  logic [2:0]  cnt;
  logic        busy;
  logic [8:0]  rem_next;
  logic [15:0] quo_next;
  logic [9:0]  rs;
  logic [9:0]  diff;

  // mean never exceeds the largest magnitude, so dividend[23:16] < divisor
  always_comb begin
    rem_next = rem;
    quo_next = quotient;
    rs       = '0;
    diff     = '0;
    for (int i = 0; i < 2; i++) begin
      rs       = {rem_next, quo_next[15]};
      diff     = rs - {1'b0, div};
      quo_next = {quo_next[14:0], 1'b0};
      if (rs >= {1'b0, div}) begin
        rem_next    = diff[8:0];
        quo_next[0] = 1'b1;
      end else begin
        rem_next = rs[8:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && (cnt == sbma_pkg::STEP_LAST);
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 3'd1;
        if (cnt == sbma_pkg::STEP_LAST) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      div      <= divisor;
      rem      <= {1'b0, dividend[23:16]};
      quotient <= dividend[15:0];
    end else if (busy) begin
      rem      <= rem_next;
      quotient <= quo_next;
    end
  end

endmodule

/* hw/rtl/spectrum_band_magnitude_average_top.sv */
// Band averager for FFT bins. Each accepted word is one complex bin; its magnitude
// (floor square root of re^2 + im^2) is added to the band sum, and after band_width
// bins a word with the floor mean, band index and last-band flag is sent. A bin passes
// through the serial sum-of-squares multiplier, then the square-root unit, is then
// accumulated, and the block returns to idle; no new bin is taken before that. A bin
// that closes a band also goes through the serial divider before the return, and then
// loads the output register, waiting for as long as that register stays full.
// Outside a frame (after band_total bands, or after reset) bins without frame_start
// are taken and dropped. Registers: band_width at 0x0, band_total at 0x4.
module spectrum_band_magnitude_average_top (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [2:0]                          paddr,
  input  logic [31:0]                         pwdata,
  output logic [31:0]                         prdata,
  output logic                                pready,
  input  logic signed [sbma_pkg::BIN_W-1:0]   bin_real,
  input  logic signed [sbma_pkg::BIN_W-1:0]   bin_imag,
  input  logic                                frame_start,
  input  logic                                bin_valid,
  output logic                                bin_ready,
  output logic [sbma_pkg::MAG_W-1:0]          band_average,
  output logic [sbma_pkg::BAND_W-1:0]         band_number,
  output logic                                final_band,
  output logic                                band_valid,
  input  logic                                band_ready
);

  sbma_pkg::state_t state;
  sbma_pkg::state_t state_next;

  logic [sbma_pkg::WIDTH_W-1:0] band_width;
  logic [sbma_pkg::TOTAL_W-1:0] band_total;
  logic [sbma_pkg::WIDTH_W-1:0] bins_in_band;
  logic [sbma_pkg::TOTAL_W-1:0] current_band;
  logic [sbma_pkg::SUM_W-1:0]   magnitude_sum;
  logic                         frame_finished;
  logic [sbma_pkg::BAND_W-1:0]  pend_band;
  logic                         pend_last;

  logic [sbma_pkg::WIDTH_W-1:0] width_eff;
  logic [sbma_pkg::TOTAL_W-1:0] total_eff;
  logic [sbma_pkg::SUM_W-1:0]   sum_next;
  logic [sbma_pkg::WIDTH_W-1:0] bins_next;
  logic                         band_close;
  logic                         last;

  logic                         sq_start;
  logic                         sq_done;
  logic [sbma_pkg::POW_W-1:0]   power;
  logic                         rt_start;
  logic                         rt_done;
  logic [sbma_pkg::MAG_W-1:0]   mag;
  logic                         dv_start;
  logic                         dv_done;
  logic [sbma_pkg::MAG_W-1:0]   quot;
  logic                         load_out;
  logic                         cfg_write;

  sbma_square u_square (
    .clk   (clk),
    .rst   (rst),
    .start (sq_start),
    .re    (bin_real),
    .im    (bin_imag),
    .done  (sq_done),
    .power (power)
  );

  sbma_isqrt u_isqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (rt_start),
    .radicand (power),
    .done     (rt_done),
    .root     (mag)
  );

  sbma_divide u_divide (
    .clk      (clk),
    .rst      (rst),
    .start    (dv_start),
    .dividend (sum_next),
    .divisor  (bins_next),
    .done     (dv_done),
    .quotient (quot)
  );

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;

  always_comb begin
    unique case (paddr[2])
      sbma_pkg::REG_BAND_WIDTH: prdata = {23'd0, band_width};
      sbma_pkg::REG_BAND_TOTAL: prdata = {22'd0, band_total};
      default:                  prdata = '0;
    endcase
  end

  always_comb begin
    if (band_width == '0) begin
      width_eff = 9'd1;
    end else if (band_width > sbma_pkg::WIDTH_MAX) begin
      width_eff = sbma_pkg::WIDTH_MAX;
    end else begin
      width_eff = band_width;
    end
    if (band_total == '0) begin
      total_eff = 10'd1;
    end else if (band_total > sbma_pkg::TOTAL_MAX) begin
      total_eff = sbma_pkg::TOTAL_MAX;
    end else begin
      total_eff = band_total;
    end
    sum_next   = magnitude_sum + {8'd0, mag};
    bins_next  = bins_in_band + 9'd1;
    band_close = bins_next >= width_eff;
    last       = ({1'b0, current_band} + 11'd1) >= {1'b0, total_eff};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sbma_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    sq_start   = 1'b0;
    rt_start   = 1'b0;
    dv_start   = 1'b0;
    bin_ready  = 1'b0;
    load_out   = 1'b0;
    unique case (state)
      sbma_pkg::ST_IDLE: begin
        bin_ready = 1'b1;
        if (bin_valid && (frame_start || !frame_finished)) begin
          sq_start   = 1'b1;
          state_next = sbma_pkg::ST_SQUARE;
        end
      end
      sbma_pkg::ST_SQUARE: begin
        if (sq_done) begin
          rt_start   = 1'b1;
          state_next = sbma_pkg::ST_ROOT;
        end
      end
      sbma_pkg::ST_ROOT: begin
        if (rt_done) begin
          state_next = sbma_pkg::ST_ACCUM;
        end
      end
      sbma_pkg::ST_ACCUM: begin
        if (band_close) begin
          dv_start   = 1'b1;
          state_next = sbma_pkg::ST_DIVIDE;
        end else begin
          state_next = sbma_pkg::ST_IDLE;
        end
      end
      sbma_pkg::ST_DIVIDE: begin
        if (dv_done) begin
          state_next = sbma_pkg::ST_EMIT;
        end
      end
      sbma_pkg::ST_EMIT: begin
        if (!band_valid || band_ready) begin
          load_out   = 1'b1;
          state_next = sbma_pkg::ST_IDLE;
        end
      end
      default: state_next = sbma_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      band_width     <= sbma_pkg::WIDTH_RESET;
      band_total     <= sbma_pkg::TOTAL_RESET;
      bins_in_band   <= '0;
      current_band   <= '0;
      magnitude_sum  <= '0;
      frame_finished <= 1'b1;
      band_valid     <= 1'b0;
    end else begin
      if (cfg_write) begin
        case (paddr[2])
          sbma_pkg::REG_BAND_WIDTH: band_width <= pwdata[8:0];
          sbma_pkg::REG_BAND_TOTAL: band_total <= pwdata[9:0];
          default: ;
        endcase
      end
      if (state == sbma_pkg::ST_IDLE && bin_valid && frame_start) begin
        bins_in_band   <= '0;
        current_band   <= '0;
        magnitude_sum  <= '0;
        frame_finished <= 1'b0;
      end
      if (state == sbma_pkg::ST_ACCUM) begin
        if (band_close) begin
          magnitude_sum <= '0;
          bins_in_band  <= '0;
          if (last) begin
            frame_finished <= 1'b1;
          end else begin
            current_band <= current_band + 10'd1;
          end
        end else begin
          magnitude_sum <= sum_next;
          bins_in_band  <= bins_next;
        end
      end
      if (load_out) begin
        band_valid <= 1'b1;
      end else if (band_valid && band_ready) begin
        band_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == sbma_pkg::ST_ACCUM && band_close) begin
      pend_band <= current_band[8:0];
      pend_last <= last;
    end
    if (load_out) begin
      band_average <= quot;
      band_number  <= pend_band;
      final_band   <= pend_last;
    end
  end

endmodule
